### sv/bcec_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bcec_pkg
// Shared types and constants for the button click event classifier.
// ----------------------------------------------------------------------------
package bcec_pkg;

    localparam int TIME_WIDTH_DEF = 32;
    localparam int NOW_WIDTH      = 32;
    localparam int CFG_WIDTH      = 16;
    localparam int CFG_IDX_WIDTH  = 2;

    localparam logic [CFG_WIDTH-1:0] DEBOUNCE_RST = 16'd50;
    localparam logic [CFG_WIDTH-1:0] LONG_RST     = 16'd1000;
    localparam logic [CFG_WIDTH-1:0] WINDOW_RST   = 16'd300;

    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        CFG_DEBOUNCE = 2'd0,
        CFG_LONG     = 2'd1,
        CFG_WINDOW   = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        EV_NONE   = 3'd0,
        EV_SINGLE = 3'd1,
        EV_DOUBLE = 3'd2,
        EV_LONG   = 3'd3,
        EV_TWO    = 3'd4,
        EV_THREE  = 3'd5,
        EV_FOUR   = 3'd6
    } t_event;

    typedef enum logic [3:0] {
        PH_IDLE   = 4'b0001,
        PH_FIRST  = 4'b0010,
        PH_WAIT   = 4'b0100,
        PH_SECOND = 4'b1000
    } t_phase;

    typedef struct packed {
        logic [CFG_WIDTH-1:0] min_press;
        logic [CFG_WIDTH-1:0] long_press;
        logic [CFG_WIDTH-1:0] window_ms;
    } t_cfg;

    typedef struct packed {
        logic one;
        logic two;
        logic three;
        logic four;
    } t_levels;

endpackage
`default_nettype wire

### sv/bcec_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bcec_core
// Classifier state and next-event logic for one poll per step.
// ----------------------------------------------------------------------------
module bcec_core
    import bcec_pkg::*;
#(
    parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_step,
    input  wire logic [TIME_WIDTH-1:0] i_now,
    input  wire t_levels               i_levels,
    input  wire t_cfg                  i_cfg,
    output t_event                     o_event
);

    t_phase                r_phase,       n_phase;
    logic [TIME_WIDTH-1:0] r_press_start, n_press_start;
    logic [TIME_WIDTH-1:0] r_release,     n_release;
    logic                  r_prev_two,    n_prev_two;
    logic                  r_prev_three,  n_prev_three;
    logic                  r_prev_four,   n_prev_four;

    logic [TIME_WIDTH-1:0] press_dur;
    logic [TIME_WIDTH-1:0] since_release;
    logic [TIME_WIDTH-1:0] debounce_ext;
    logic [TIME_WIDTH-1:0] long_ext;
    logic [TIME_WIDTH-1:0] window_ext;
    t_event                ev_one;
    t_event                ev;

    // differences wrap modulo 2^TIME_WIDTH
    assign press_dur     = i_now - r_press_start;
    assign since_release = i_now - r_release;
    assign debounce_ext  = TIME_WIDTH'(i_cfg.min_press);
    assign long_ext      = TIME_WIDTH'(i_cfg.long_press);
    assign window_ext    = TIME_WIDTH'(i_cfg.window_ms);

    always_comb begin
        n_phase       = r_phase;
        n_press_start = r_press_start;
        n_release     = r_release;
        ev_one        = EV_NONE;
        case (r_phase)
            PH_IDLE: begin
                if (!i_levels.one) begin
                    n_press_start = i_now;
                    n_phase       = PH_FIRST;
                end
            end
            PH_FIRST: begin
                if (i_levels.one) begin
                    // long test wins over debounce
                    if (press_dur >= long_ext) begin
                        n_phase = PH_IDLE;
                        ev_one  = EV_LONG;
                    end else if (press_dur >= debounce_ext) begin
                        n_release = i_now;
                        n_phase   = PH_WAIT;
                    end else begin
                        n_phase = PH_IDLE;
                    end
                end
            end
            PH_WAIT: begin
                if (!i_levels.one) begin
                    n_press_start = i_now;
                    n_phase       = PH_SECOND;
                end else if (since_release >= window_ext) begin
                    n_phase = PH_IDLE;
                    ev_one  = EV_SINGLE;
                end
            end
            PH_SECOND: begin
                if (i_levels.one) begin
                    n_phase = PH_IDLE;
                    if (press_dur >= debounce_ext) begin
                        ev_one = EV_DOUBLE;
                    end
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
    end

    // edges on buttons two to four; a reported edge skips the later buttons
    always_comb begin
        n_prev_two   = r_prev_two;
        n_prev_three = r_prev_three;
        n_prev_four  = r_prev_four;
        ev           = ev_one;
        if (ev_one == EV_NONE) begin
            n_prev_two = i_levels.two;
            if (!i_levels.two && r_prev_two) begin
                ev = EV_TWO;
            end else begin
                n_prev_three = i_levels.three;
                if (!i_levels.three && r_prev_three) begin
                    ev = EV_THREE;
                end else begin
                    n_prev_four = i_levels.four;
                    if (!i_levels.four && r_prev_four) begin
                        ev = EV_FOUR;
                    end
                end
            end
        end
    end

    assign o_event = ev;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_press_start <= '0;
            r_release     <= '0;
            r_prev_two    <= 1'b1;
            r_prev_three  <= 1'b1;
            r_prev_four   <= 1'b1;
        end else if (i_step) begin
            r_phase       <= n_phase;
            r_press_start <= n_press_start;
            r_release     <= n_release;
            r_prev_two    <= n_prev_two;
            r_prev_three  <= n_prev_three;
            r_prev_four   <= n_prev_four;
        end
    end

endmodule
`default_nettype wire

### sv/button_click_event_classifier.sv
`default_nettype none
// ----------------------------------------------------------------------------
// button_click_event_classifier
// Per-poll single/double/long click detector plus edge presses on buttons two to four.
// ----------------------------------------------------------------------------
// Each accepted word is one poll (timestamp plus four active-low levels) and
// yields exactly one event code word. A new poll can be accepted every clock
// while o_in_stall is low; the accepting edge loads the input register, and
// the classifier update moves into the output register when the output side
// advances. The output register decouples the sides, so input is
// stalled only while both registers hold a word and the output side is
// stalled. Timestamps are kept modulo 2^TIME_WIDTH. Write configuration only
// while no poll is in flight.
// ----------------------------------------------------------------------------
module button_click_event_classifier
    import bcec_pkg::*;
#(
    parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_in_valid,
    output logic                          o_in_stall,
    input  wire logic [NOW_WIDTH-1:0]     i_now_ms,
    input  wire logic                     i_level_one,
    input  wire logic                     i_level_two,
    input  wire logic                     i_level_three,
    input  wire logic                     i_level_four,
    output logic                          o_out_valid,
    input  wire logic                     i_out_stall,
    output logic [2:0]                    o_event_code,
    input  wire logic                     i_cfg_we,
    input  wire logic [CFG_IDX_WIDTH-1:0] i_cfg_index,
    input  wire logic [CFG_WIDTH-1:0]     i_cfg_data
);

    t_cfg                  r_cfg;
    logic                  r_in_valid;
    logic [TIME_WIDTH-1:0] r_now;
    t_levels               r_levels;
    logic                  r_out_valid;
    logic [2:0]            r_event;

    logic                  advance;
    logic                  step;
    logic [TIME_WIDTH-1:0] now_trim;
    t_event                core_event;

    generate
        if (TIME_WIDTH >= NOW_WIDTH) begin : g_now_ext
            assign now_trim = TIME_WIDTH'(i_now_ms);
        end else begin : g_now_cut
            assign now_trim = i_now_ms[TIME_WIDTH-1:0];
        end
    endgenerate

    assign advance    = !r_out_valid || !i_out_stall;
    assign step       = r_in_valid && advance;
    assign o_in_stall = r_in_valid && !advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_press  <= DEBOUNCE_RST;
            r_cfg.long_press <= LONG_RST;
            r_cfg.window_ms  <= WINDOW_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_DEBOUNCE: r_cfg.min_press  <= i_cfg_data;
                CFG_LONG:     r_cfg.long_press <= i_cfg_data;
                CFG_WINDOW:   r_cfg.window_ms  <= i_cfg_data;
                default:      ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_now          <= now_trim;
            r_levels.one   <= i_level_one;
            r_levels.two   <= i_level_two;
            r_levels.three <= i_level_three;
            r_levels.four  <= i_level_four;
        end
    end

    bcec_core #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_now    (r_now),
        .i_levels (r_levels),
        .i_cfg    (r_cfg),
        .o_event  (core_event)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_event <= core_event;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_event_code = r_event;

endmodule
`default_nettype wire
